// ----- rtl/rspf_pkg.sv -----
// Shared types, constants and codes of the ramped speed position follower.
package rspf_pkg;

  localparam int unsigned PosW     = 32;
  localparam int unsigned SpdW     = 31;
  localparam int unsigned ElW      = 24;
  localparam int unsigned KindW    = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned NumAxes  = 3;
  localparam int unsigned AxisW    = 2;
  localparam int unsigned FracW    = 16;
  localparam int unsigned MagW     = 48;
  localparam int unsigned StepW    = 56;
  localparam int unsigned DivCntW  = 5;

  localparam logic [DivCntW-1:0] DivLast = DivCntW'(SpdW - 1);

  localparam logic [AxisW-1:0] AXIS_X = 2'd0;
  localparam logic [AxisW-1:0] AXIS_Y = 2'd1;
  localparam logic [AxisW-1:0] AXIS_Z = 2'd2;

  localparam logic [KindW-1:0] KIND_TICK  = 2'd0;
  localparam logic [KindW-1:0] KIND_SNAP  = 2'd1;
  localparam logic [KindW-1:0] KIND_CHASE = 2'd2;
  localparam logic [KindW-1:0] KIND_ZOOM  = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_MIN_SPEED = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SPEED = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RAMP_DIST = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET_X  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET_Y  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET_Z  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_AXIS_EN   = 3'd6;

  localparam logic [SpdW-1:0]    MinSpeedRst = 31'd655360;
  localparam logic [SpdW-1:0]    MaxSpeedRst = 31'd13107200;
  localparam logic [SpdW-1:0]    RampDistRst = 31'd6553600;
  localparam logic [PosW-1:0]    OneQ16      = 32'd65536;
  localparam logic [NumAxes-1:0] AxisEnRst   = 3'b111;

  typedef struct packed {
    logic [SpdW-1:0]    min_speed;
    logic [SpdW-1:0]    max_speed;
    logic [SpdW-1:0]    ramp_distance;
    logic [PosW-1:0]    bias_x;
    logic [PosW-1:0]    bias_y;
    logic [PosW-1:0]    bias_z;
    logic [NumAxes-1:0] axis_enable;
  } cfg_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [PosW-1:0]  target_x;
    logic [PosW-1:0]  target_y;
    logic [PosW-1:0]  target_z;
    logic             use_x;
    logic             use_y;
    logic             use_z;
    logic [ElW-1:0]   elapsed;
  } item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ITEM,
    OP_DIFF,
    OP_CLASS,
    OP_DIVLD,
    OP_DIV,
    OP_DIVEND,
    OP_ZMUL,
    OP_MAG,
    OP_MLO,
    OP_MHI,
    OP_STEP,
    OP_UPD,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [AxisW-1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic               move_req;
    logic               snap_pending;
    logic [NumAxes-1:0] axis_enable;
    logic               dist_zero;
    logic               need_ramp;
    logic               mag_zero;
    logic               out_free;
  } dp_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_CLASS,
    S_DIVLD,
    S_DIV,
    S_DIVEND,
    S_ZMUL,
    S_MAG,
    S_MLO,
    S_MHI,
    S_STEP,
    S_UPD,
    S_NEXT,
    S_FIN
  } ctrl_state_e;

endpackage

// ----- rtl/rspf_if.sv -----
// Valid/ready channel interfaces for input items and camera results.
interface rspf_in_if;
  import rspf_pkg::*;

  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [PosW-1:0]  target_x;
  logic [PosW-1:0]  target_y;
  logic [PosW-1:0]  target_z;
  logic             use_x;
  logic             use_y;
  logic             use_z;
  logic [ElW-1:0]   elapsed;

  modport source (
    output valid, kind, target_x, target_y, target_z, use_x, use_y, use_z, elapsed,
    input  ready
  );
  modport sink (
    input  valid, kind, target_x, target_y, target_z, use_x, use_y, use_z, elapsed,
    output ready
  );
endinterface

interface rspf_out_if;
  import rspf_pkg::*;

  logic            valid;
  logic            ready;
  logic [PosW-1:0] position_x;
  logic [PosW-1:0] position_y;
  logic [PosW-1:0] zoom_out;

  modport source (
    output valid, position_x, position_y, zoom_out,
    input  ready
  );
  modport sink (
    input  valid, position_x, position_y, zoom_out,
    output ready
  );
endinterface

// ----- rtl/ramped_speed_position_follower_top.sv -----
// Goal items, snap ticks and ticks with zero elapsed time go straight to the result. A moving
// tick steps each enabled axis in turn, the x and y axes with an extra zoom multiply, and runs
// the 31-step shared divider for each axis inside the ramp; one item is in work at a time.
// Reset puts camera and goal at (0, 0, 1.0), clears the pending snap and loads the register
// defaults; a finished result waits in the output register while the next item is accepted.
module ramped_speed_position_follower_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  rspf_in_if.sink                            in_if,
  rspf_out_if.source                         out_if,
  input  logic                               cfg_we_i,
  input  logic [rspf_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [rspf_pkg::CfgDataW-1:0]      cfg_data_i
);
  import rspf_pkg::*;

  cfg_t       cfg_q;
  item_t      item;
  dp_cmd_t    cmd;
  dp_status_t st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_speed     <= MinSpeedRst;
      cfg_q.max_speed     <= MaxSpeedRst;
      cfg_q.ramp_distance <= RampDistRst;
      cfg_q.bias_x        <= '0;
      cfg_q.bias_y        <= '0;
      cfg_q.bias_z        <= OneQ16;
      cfg_q.axis_enable   <= AxisEnRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_SPEED: cfg_q.min_speed     <= cfg_data_i[SpdW-1:0];
        CFG_MAX_SPEED: cfg_q.max_speed     <= cfg_data_i[SpdW-1:0];
        CFG_RAMP_DIST: cfg_q.ramp_distance <= cfg_data_i[SpdW-1:0];
        CFG_OFFSET_X:  cfg_q.bias_x        <= cfg_data_i[PosW-1:0];
        CFG_OFFSET_Y:  cfg_q.bias_y        <= cfg_data_i[PosW-1:0];
        CFG_OFFSET_Z:  cfg_q.bias_z        <= cfg_data_i[PosW-1:0];
        CFG_AXIS_EN:   cfg_q.axis_enable   <= cfg_data_i[NumAxes-1:0];
        default: ;
      endcase
    end
  end

  assign item.kind     = in_if.kind;
  assign item.target_x = in_if.target_x;
  assign item.target_y = in_if.target_y;
  assign item.target_z = in_if.target_z;
  assign item.use_x    = in_if.use_x;
  assign item.use_y    = in_if.use_y;
  assign item.use_z    = in_if.use_z;
  assign item.elapsed  = in_if.elapsed;

  rspf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (st),
    .cmd_o      (cmd)
  );

  rspf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (item),
    .cmd_i       (cmd),
    .status_o    (st),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .pos_x_o     (out_if.position_x),
    .pos_y_o     (out_if.position_y),
    .zoom_o      (out_if.zoom_out)
  );

`ifndef ASSERT_OFF
  a_snap_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready && (in_if.kind == KIND_SNAP) |=> st.snap_pending)
    else $error("snap request did not leave a pending snap");

  a_tick_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready && (in_if.kind == KIND_TICK) |=> !st.snap_pending)
    else $error("pending snap survived a tick");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("second transaction accepted while an item is in work");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_OUT) |=> out_if.valid)
    else $error("result load did not raise output valid");
`endif

endmodule

// ----- rtl/rspf_ctrl.sv -----
// Sequencer that steps the shared datapath through goal updates and the per-axis follow.
module rspf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rspf_pkg::dp_status_t  status_i,
  output rspf_pkg::dp_cmd_t     cmd_o
);
  import rspf_pkg::*;

  ctrl_state_e        state_q, state_d;
  logic [AxisW-1:0]   axis_q, axis_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               scaled;

  // The x and y axes are scaled by zoom; the zoom axis is not.
  assign scaled = (axis_q != AXIS_Z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      axis_q  <= AXIS_X;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          axis_d  = AXIS_X;
          state_d = status_i.move_req ? S_DIFF : S_FIN;
        end
      end
      S_DIFF: begin
        state_d = status_i.axis_enable[axis_q] ? S_CLASS : S_NEXT;
      end
      S_CLASS: begin
        if (status_i.dist_zero) begin
          state_d = S_NEXT;
        end else if (status_i.need_ramp) begin
          state_d = S_DIVLD;
        end else begin
          state_d = scaled ? S_ZMUL : S_MAG;
        end
      end
      S_DIVLD: begin
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          state_d = S_DIVEND;
        end
      end
      S_DIVEND: state_d = scaled ? S_ZMUL : S_MAG;
      S_ZMUL:   state_d = S_MAG;
      S_MAG:    state_d = S_MLO;
      S_MLO:    state_d = status_i.mag_zero ? S_NEXT : S_MHI;
      S_MHI:    state_d = S_STEP;
      S_STEP:   state_d = S_UPD;
      S_UPD:    state_d = S_NEXT;
      S_NEXT: begin
        if (axis_q == AXIS_Z) begin
          state_d = S_FIN;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = S_DIFF;
        end
      end
      S_FIN: begin
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o.op    = OP_NONE;
    cmd_o.axis  = axis_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_ITEM;
        end
      end
      S_DIFF:   cmd_o.op = OP_DIFF;
      S_CLASS:  cmd_o.op = OP_CLASS;
      S_DIVLD:  cmd_o.op = OP_DIVLD;
      S_DIV:    cmd_o.op = OP_DIV;
      S_DIVEND: cmd_o.op = OP_DIVEND;
      S_ZMUL:   cmd_o.op = OP_ZMUL;
      S_MAG:    cmd_o.op = OP_MAG;
      S_MLO:    cmd_o.op = OP_MLO;
      S_MHI:    cmd_o.op = OP_MHI;
      S_STEP:   cmd_o.op = OP_STEP;
      S_UPD:    cmd_o.op = OP_UPD;
      S_NEXT:   cmd_o.op = OP_NONE;
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_OUT;
        end
      end
      default:  cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// ----- rtl/rspf_dp.sv -----
// Datapath: camera and goal state, shared multiplier, restoring divider and output register.
module rspf_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rspf_pkg::cfg_t               cfg_i,
  input  rspf_pkg::item_t              item_i,
  input  rspf_pkg::dp_cmd_t            cmd_i,
  output rspf_pkg::dp_status_t         status_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [rspf_pkg::PosW-1:0]    pos_x_o,
  output logic [rspf_pkg::PosW-1:0]    pos_y_o,
  output logic [rspf_pkg::PosW-1:0]    zoom_o
);
  import rspf_pkg::*;

  localparam int unsigned TgtW    = PosW + 1;
  localparam int unsigned DiffW   = PosW + 2;
  localparam int unsigned ProdW   = 2 * PosW;
  localparam int unsigned AccW    = PosW + ElW;
  localparam int unsigned HiW     = MagW - PosW;
  localparam int unsigned HiProdW = HiW + ElW;
  localparam int unsigned SumW    = HiProdW + PosW;
  localparam int unsigned NwW     = StepW + 1;

  localparam logic [NwW-1:0]  NwMax  = NwW'(64'h0000_0000_7FFF_FFFF);
  localparam logic [NwW-1:0]  NwMin  = ~NwMax;
  localparam logic [PosW-1:0] PosMax = {1'b0, {(PosW-1){1'b1}}};
  localparam logic [PosW-1:0] PosMin = {1'b1, {(PosW-1){1'b0}}};

  logic [PosW-1:0]  cam_x_q, cam_y_q, cam_z_q;
  logic [PosW-1:0]  goal_x_q, goal_y_q, goal_z_q;
  logic             snap_q;
  logic             out_valid_q;
  logic [PosW-1:0]  out_x_q, out_y_q, out_z_q;

  logic [ElW-1:0]   el_q;
  logic [TgtW-1:0]  tgt_q;
  logic [TgtW-1:0]  dist_q;
  logic             neg_q;
  logic [SpdW-1:0]  sp_q;
  logic [SpdW-1:0]  rem_q, dlo_q, quo_q;
  logic [ProdW-1:0] prod_q;
  logic [MagW-1:0]  mag_q;
  logic             dir_neg_q;
  logic [AccW-1:0]  acc_q;
  logic [StepW-1:0] step_q;

  logic [PosW-1:0]  cam_sel, goal_sel, off_sel;
  logic [TgtW-1:0]  tgt;
  logic [DiffW-1:0] diff, diff_mag;
  logic             max_le_min;
  logic [SpdW-1:0]  spd_span;
  logic [PosW-1:0]  zoom_abs;
  logic [PosW-1:0]  mul_a, mul_b;
  logic [ProdW-1:0] mul_p;
  logic [PosW-1:0]  div_t, div_sub;
  logic             div_ge;
  logic [ProdW-1:0] prod_rnd;
  logic [SumW-1:0]  step_sum;
  logic [NwW-1:0]   cam_ext, tgt_ext, step_ext, nw_raw, nw_clamp;
  logic [PosW-1:0]  new_pos;

  always_comb begin
    case (cmd_i.axis)
      AXIS_X: begin
        cam_sel  = cam_x_q;
        goal_sel = goal_x_q;
        off_sel  = cfg_i.bias_x;
      end
      AXIS_Y: begin
        cam_sel  = cam_y_q;
        goal_sel = goal_y_q;
        off_sel  = cfg_i.bias_y;
      end
      default: begin
        cam_sel  = cam_z_q;
        goal_sel = goal_z_q;
        off_sel  = cfg_i.bias_z;
      end
    endcase
  end

  // Target and distance at full precision, so neither can wrap.
  assign tgt      = {goal_sel[PosW-1], goal_sel} + {off_sel[PosW-1], off_sel};
  assign diff     = {tgt[TgtW-1], tgt} - {{2{cam_sel[PosW-1]}}, cam_sel};
  assign diff_mag = diff[DiffW-1] ? (~diff + DiffW'(1)) : diff;

  assign max_le_min = (cfg_i.max_speed <= cfg_i.min_speed);
  assign spd_span   = cfg_i.max_speed - cfg_i.min_speed;
  assign zoom_abs   = cam_z_q[PosW-1] ? (~cam_z_q + PosW'(1)) : cam_z_q;

  always_comb begin
    case (cmd_i.op)
      OP_CLASS: begin
        mul_a = {1'b0, spd_span};
        mul_b = {1'b0, dist_q[SpdW-1:0]};
      end
      OP_ZMUL: begin
        mul_a = {1'b0, sp_q};
        mul_b = zoom_abs;
      end
      OP_MLO: begin
        mul_a = mag_q[PosW-1:0];
        mul_b = {{(PosW-ElW){1'b0}}, el_q};
      end
      OP_MHI: begin
        mul_a = {{(PosW-HiW){1'b0}}, mag_q[MagW-1:PosW]};
        mul_b = {{(PosW-ElW){1'b0}}, el_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

  // One quotient bit per cycle; the partial remainder always stays below the ramp distance.
  assign div_t   = {rem_q, dlo_q[SpdW-1]};
  assign div_ge  = (div_t >= {1'b0, cfg_i.ramp_distance});
  assign div_sub = div_t - {1'b0, cfg_i.ramp_distance};

  // A negative zoom floors the scaled speed, which rounds its magnitude up.
  assign prod_rnd = prod_q + ProdW'((1 << FracW) - 1);

  assign step_sum = {prod_q[HiProdW-1:0], {PosW{1'b0}}} + {{(SumW-AccW){1'b0}}, acc_q};

  assign cam_ext  = {{(NwW-PosW){cam_sel[PosW-1]}}, cam_sel};
  assign tgt_ext  = {{(NwW-TgtW){tgt_q[TgtW-1]}}, tgt_q};
  assign step_ext = {1'b0, step_q};
  assign nw_raw   = dir_neg_q ? (cam_ext - step_ext) : (cam_ext + step_ext);

  always_comb begin
    nw_clamp = nw_raw;
    if (!dir_neg_q && ($signed(nw_raw) > $signed(tgt_ext))) begin
      nw_clamp = tgt_ext;
    end else if (dir_neg_q && ($signed(nw_raw) < $signed(tgt_ext))) begin
      nw_clamp = tgt_ext;
    end
    if ($signed(nw_clamp) > $signed(NwMax)) begin
      new_pos = PosMax;
    end else if ($signed(nw_clamp) < $signed(NwMin)) begin
      new_pos = PosMin;
    end else begin
      new_pos = nw_clamp[PosW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q     <= '0;
      cam_y_q     <= '0;
      cam_z_q     <= OneQ16;
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      goal_z_q    <= OneQ16;
      snap_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_ITEM: begin
          case (item_i.kind)
            KIND_SNAP: begin
              goal_x_q <= item_i.target_x;
              goal_y_q <= item_i.target_y;
              goal_z_q <= item_i.target_z;
              snap_q   <= 1'b1;
            end
            KIND_CHASE: begin
              if (item_i.use_x) goal_x_q <= item_i.target_x;
              if (item_i.use_y) goal_y_q <= item_i.target_y;
              if (item_i.use_z) goal_z_q <= item_i.target_z;
            end
            KIND_ZOOM: goal_z_q <= item_i.target_z;
            default: begin
              if (snap_q) begin
                cam_x_q <= goal_x_q;
                cam_y_q <= goal_y_q;
                cam_z_q <= goal_z_q;
                snap_q  <= 1'b0;
              end
            end
          endcase
        end
        OP_UPD: begin
          case (cmd_i.axis)
            AXIS_X:  cam_x_q <= new_pos;
            AXIS_Y:  cam_y_q <= new_pos;
            default: cam_z_q <= new_pos;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ITEM: el_q <= item_i.elapsed;
      OP_DIFF: begin
        tgt_q  <= tgt;
        dist_q <= diff_mag[TgtW-1:0];
        neg_q  <= diff[DiffW-1];
      end
      OP_CLASS: begin
        sp_q   <= max_le_min ? cfg_i.min_speed : cfg_i.max_speed;
        prod_q <= mul_p;
      end
      OP_DIVLD: begin
        rem_q <= prod_q[2*SpdW-1:SpdW];
        dlo_q <= prod_q[SpdW-1:0];
      end
      OP_DIV: begin
        rem_q <= div_ge ? div_sub[SpdW-1:0] : div_t[SpdW-1:0];
        dlo_q <= {dlo_q[SpdW-2:0], 1'b0};
        quo_q <= {quo_q[SpdW-2:0], div_ge};
      end
      OP_DIVEND: sp_q <= cfg_i.min_speed + quo_q;
      OP_ZMUL:   prod_q <= mul_p;
      OP_MAG: begin
        if (cmd_i.axis != AXIS_Z) begin
          mag_q     <= cam_z_q[PosW-1] ? prod_rnd[FracW +: MagW] : prod_q[FracW +: MagW];
          dir_neg_q <= neg_q ^ cam_z_q[PosW-1];
        end else begin
          mag_q     <= {{(MagW-SpdW){1'b0}}, sp_q};
          dir_neg_q <= neg_q;
        end
      end
      OP_MLO: prod_q <= mul_p;
      OP_MHI: begin
        acc_q  <= prod_q[AccW-1:0];
        prod_q <= mul_p;
      end
      OP_STEP: step_q <= step_sum[SumW-1:FracW];
      OP_OUT: begin
        out_x_q <= cam_x_q;
        out_y_q <= cam_y_q;
        out_z_q <= cam_z_q;
      end
      default: ;
    endcase
  end

  assign status_o.move_req     = (item_i.kind == KIND_TICK) && !snap_q && (item_i.elapsed != '0);
  assign status_o.snap_pending = snap_q;
  assign status_o.axis_enable  = cfg_i.axis_enable;
  assign status_o.dist_zero    = (dist_q == '0);
  assign status_o.need_ramp    = !max_le_min && (cfg_i.ramp_distance != '0)
                                 && (dist_q < {2'b00, cfg_i.ramp_distance});
  assign status_o.mag_zero     = (mag_q == '0);
  assign status_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_x_q;
  assign pos_y_o     = out_y_q;
  assign zoom_o      = out_z_q;

endmodule
